[rtl/msx_pkg.sv]
// Shared types and constants for the MIPS subset executor.
// Opcode and function codes, flow kinds and the register write-back bundle.
// No dependencies.
package msx_pkg;

    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_J     = 6'd2;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_ADDIU = 6'd9;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_SW    = 6'd43;
    localparam logic [5:0] OP_HALT  = 6'd63;

    localparam logic [5:0] FN_ADDU = 6'd33;
    localparam logic [5:0] FN_SUBU = 6'd35;
    localparam logic [5:0] FN_AND  = 6'd36;
    localparam logic [5:0] FN_OR   = 6'd37;
    localparam logic [5:0] FN_NOR  = 6'd39;

    typedef enum logic [2:0] {
        FLOW_SEQ     = 3'd0,
        FLOW_BRANCH  = 3'd1,
        FLOW_JUMP    = 3'd2,
        FLOW_HALT    = 3'd3,
        FLOW_ILLEGAL = 3'd4
    } flow_t;

    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [31:0] data;
    } wb_t;

endpackage

[rtl/msx_regfile.sv]
// 32 x 32 register file with registered reads and per-entry valid bits.
// Depends on msx_pkg (wb_t). A write that lands on a held read address
// refreshes the held read data.
module msx_regfile (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rd_en,
    input  logic [4:0]     rs_addr,
    input  logic [4:0]     rt_addr,
    input  msx_pkg::wb_t   wb,
    output logic [31:0]    rs_data,
    output logic [31:0]    rt_data
);

    logic [31:0] mem_reg [32];
    logic [31:0] rf_valid_reg, rf_valid_next;
    logic [4:0]  rs_idx_reg, rs_idx_next;
    logic [4:0]  rt_idx_reg, rt_idx_next;
    logic        rs_vld_reg, rs_vld_next;
    logic        rt_vld_reg, rt_vld_next;
    logic [31:0] rs_val_reg;
    logic [31:0] rt_val_reg;
    logic        rs_hit;
    logic        rt_hit;

    assign rs_idx_next = rd_en ? rs_addr : rs_idx_reg;
    assign rt_idx_next = rd_en ? rt_addr : rt_idx_reg;
    assign rs_hit      = wb.en && (wb.addr == rs_idx_next);
    assign rt_hit      = wb.en && (wb.addr == rt_idx_next);

    always_comb
    begin
        rf_valid_next = rf_valid_reg;
        if (wb.en)
        begin
            rf_valid_next[wb.addr] = 1'b1;
        end
        rs_vld_next = rs_vld_reg;
        if (rs_hit)
        begin
            rs_vld_next = 1'b1;
        end
        else if (rd_en)
        begin
            rs_vld_next = rf_valid_reg[rs_addr];
        end
        rt_vld_next = rt_vld_reg;
        if (rt_hit)
        begin
            rt_vld_next = 1'b1;
        end
        else if (rd_en)
        begin
            rt_vld_next = rf_valid_reg[rt_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
            rs_idx_reg   <= '0;
            rt_idx_reg   <= '0;
            rs_vld_reg   <= 1'b0;
            rt_vld_reg   <= 1'b0;
        end
        else
        begin
            rf_valid_reg <= rf_valid_next;
            rs_idx_reg   <= rs_idx_next;
            rt_idx_reg   <= rt_idx_next;
            rs_vld_reg   <= rs_vld_next;
            rt_vld_reg   <= rt_vld_next;
        end
    end

    // write-first: a write in the same cycle wins over the array
    always_ff @(posedge clk)
    begin
        if (wb.en)
        begin
            mem_reg[wb.addr] <= wb.data;
        end
        if (rs_hit)
        begin
            rs_val_reg <= wb.data;
        end
        else if (rd_en)
        begin
            rs_val_reg <= mem_reg[rs_addr];
        end
        if (rt_hit)
        begin
            rt_val_reg <= wb.data;
        end
        else if (rd_en)
        begin
            rt_val_reg <= mem_reg[rt_addr];
        end
    end

    assign rs_data = rs_vld_reg ? rs_val_reg : '0;
    assign rt_data = rt_vld_reg ? rt_val_reg : '0;

endmodule

[rtl/msx_dmem.sv]
// Word-addressed data memory, single port, registered read.
// Sweeps every entry to zero after reset; init_done rises when the sweep ends.
// No package dependencies.
module msx_dmem #(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_en,
    input  logic                     req_we,
    input  logic [$clog2(DEPTH)-1:0] req_addr,
    input  logic [31:0]              req_wdata,
    output logic [31:0]              rdata,
    output logic                     init_done
);

    localparam int AW = $clog2(DEPTH);

    logic [31:0]   mem_reg [DEPTH];
    logic [31:0]   rdata_reg;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          clr_busy_reg, clr_busy_next;
    logic          clr_last;

    assign clr_last = (clr_addr_reg == AW'(DEPTH - 1));

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_last)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem_reg[clr_addr_reg] <= '0;
        end
        else if (req_en && req_we)
        begin
            mem_reg[req_addr] <= req_wdata;
        end
        if (req_en && !req_we)
        begin
            rdata_reg <= mem_reg[req_addr];
        end
    end

    assign rdata     = rdata_reg;
    assign init_done = !clr_busy_reg;

endmodule

[rtl/mips_subset_executor.sv]
// Channel  Handshake              Payload
// in       in_valid / in_ready    instr_word[31:0]
// out      out_valid / out_ready  flow_kind[2:0], branch_offset[15:0], jump_target[25:0]
//
// Three stages: execute (S1), memory address and access (S2), result and
// register write-back (S3). One instruction per cycle while nothing stalls; an accepted
// instruction moves through the S1, S2 and S3 registers and its result is offered from
// S3. An instruction whose source is the target of the lw just ahead of it waits in S1
// until the lw leaves S2, for the data memory's registered read. After reset the data
// memory is swept to zero; in_ready stays low meanwhile. A stalled out channel holds the
// stages back in turn. Depends on msx_pkg, msx_regfile, msx_dmem.
module mips_subset_executor #(
    parameter int MEM_DEPTH = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        instr_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         flow_kind,
    output logic signed [15:0] branch_offset,
    output logic [25:0]        jump_target
);

    localparam int AW  = $clog2(MEM_DEPTH);
    localparam int KSH = 32 + AW;
    localparam int QW  = 65 - KSH;
    localparam logic [64:0] POW_K   = 65'd1 << KSH;
    localparam logic [64:0] RECIP_W = (POW_K + 65'(MEM_DEPTH) - 65'd1) / 65'(MEM_DEPTH);
    localparam logic [32:0] RECIP   = RECIP_W[32:0];

    // handshake and stage control
    logic in_accept;
    logic init_done;
    logic load_hazard;
    logic s1_advance;
    logic s2_advance;
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;

    // S1
    logic [31:0]    s1_instr_reg;
    logic [5:0]     op;
    logic [4:0]     rs;
    logic [4:0]     rt;
    logic [4:0]     rd;
    logic [5:0]     funct;
    logic [15:0]    imm;
    logic [31:0]    imm_sext;
    logic [31:0]    rf_rs;
    logic [31:0]    rf_rt;
    logic [31:0]    op_a;
    logic [31:0]    op_b;
    msx_pkg::flow_t ex_kind;
    logic [15:0]    ex_boff;
    logic [25:0]    ex_jtgt;
    logic           ex_wb_en;
    logic [4:0]     ex_wb_addr;
    logic [31:0]    ex_alu;
    logic           ex_lw;
    logic           ex_sw;
    logic [31:0]    ex_sum;
    logic [64:0]    ex_prod;

    // S2
    msx_pkg::flow_t s2_kind_reg;
    logic [15:0]    s2_boff_reg;
    logic [25:0]    s2_jtgt_reg;
    logic           s2_wb_en_reg;
    logic [4:0]     s2_wb_addr_reg;
    logic [31:0]    s2_alu_reg;
    logic           s2_lw_reg;
    logic           s2_sw_reg;
    logic [31:0]    s2_sum_reg;
    logic [QW-1:0]  s2_q_reg;
    logic [31:0]    s2_store_reg;
    logic [32:0]    s2_qd;
    logic [AW-1:0]  mem_addr;
    logic           dmem_en;
    logic [31:0]    dmem_rdata;

    // S3
    msx_pkg::flow_t s3_kind_reg;
    logic [15:0]    s3_boff_reg;
    logic [25:0]    s3_jtgt_reg;
    logic           s3_wb_en_reg;
    logic [4:0]     s3_wb_addr_reg;
    logic [31:0]    s3_alu_reg;
    logic           s3_lw_reg;
    logic [31:0]    s3_wb_data;
    msx_pkg::wb_t   commit;

    assign in_accept   = in_valid && in_ready;
    assign load_hazard = s2_valid_reg && s2_lw_reg
                         && ((s2_wb_addr_reg == rs) || (s2_wb_addr_reg == rt));
    assign s2_advance  = s2_valid_reg && (!s3_valid_reg || out_ready);
    assign s1_advance  = s1_valid_reg && !load_hazard && (!s2_valid_reg || s2_advance);
    assign in_ready    = init_done && (!s1_valid_reg || s1_advance);

    assign s1_valid_next = in_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
    assign s2_valid_next = s1_advance ? 1'b1 : (s2_advance ? 1'b0 : s2_valid_reg);
    assign s3_valid_next = s2_advance ? 1'b1 : (out_ready ? 1'b0 : s3_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_instr_reg <= instr_word;
        end
    end

    msx_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rs_addr (instr_word[25:21]),
        .rt_addr (instr_word[20:16]),
        .wb      (commit),
        .rs_data (rf_rs),
        .rt_data (rf_rt)
    );

    assign op       = s1_instr_reg[31:26];
    assign rs       = s1_instr_reg[25:21];
    assign rt       = s1_instr_reg[20:16];
    assign rd       = s1_instr_reg[15:11];
    assign funct    = s1_instr_reg[5:0];
    assign imm      = s1_instr_reg[15:0];
    assign imm_sext = {{16{imm[15]}}, imm};

    // forward from the younger write first; a load in S2 is covered by the stall
    always_comb
    begin
        op_a = rf_rs;
        op_b = rf_rt;
        if (s2_valid_reg && s2_wb_en_reg && !s2_lw_reg && (s2_wb_addr_reg == rs))
        begin
            op_a = s2_alu_reg;
        end
        else if (s3_valid_reg && s3_wb_en_reg && (s3_wb_addr_reg == rs))
        begin
            op_a = s3_wb_data;
        end
        if (s2_valid_reg && s2_wb_en_reg && !s2_lw_reg && (s2_wb_addr_reg == rt))
        begin
            op_b = s2_alu_reg;
        end
        else if (s3_valid_reg && s3_wb_en_reg && (s3_wb_addr_reg == rt))
        begin
            op_b = s3_wb_data;
        end
    end

    always_comb
    begin
        ex_kind    = msx_pkg::FLOW_SEQ;
        ex_boff    = '0;
        ex_jtgt    = '0;
        ex_wb_en   = 1'b0;
        ex_wb_addr = rt;
        ex_alu     = '0;
        ex_lw      = 1'b0;
        ex_sw      = 1'b0;
        unique case (op)
            msx_pkg::OP_RTYPE:
            begin
                ex_wb_addr = rd;
                unique case (funct)
                    msx_pkg::FN_ADDU:
                    begin
                        ex_wb_en = 1'b1;
                        ex_alu   = op_a + op_b;
                    end
                    msx_pkg::FN_SUBU:
                    begin
                        ex_wb_en = 1'b1;
                        ex_alu   = op_a - op_b;
                    end
                    msx_pkg::FN_AND:
                    begin
                        ex_wb_en = 1'b1;
                        ex_alu   = op_a & op_b;
                    end
                    msx_pkg::FN_OR:
                    begin
                        ex_wb_en = 1'b1;
                        ex_alu   = op_a | op_b;
                    end
                    msx_pkg::FN_NOR:
                    begin
                        ex_wb_en = 1'b1;
                        ex_alu   = ~(op_a | op_b);
                    end
                    default:
                    begin
                        ex_kind = msx_pkg::FLOW_ILLEGAL;
                    end
                endcase
            end
            msx_pkg::OP_ADDIU:
            begin
                ex_wb_en = 1'b1;
                ex_alu   = op_a + imm_sext;
            end
            msx_pkg::OP_BEQ:
            begin
                if (op_a == op_b)
                begin
                    ex_kind = msx_pkg::FLOW_BRANCH;
                    ex_boff = imm;
                end
            end
            msx_pkg::OP_J:
            begin
                ex_kind = msx_pkg::FLOW_JUMP;
                ex_jtgt = s1_instr_reg[25:0];
            end
            msx_pkg::OP_LW:
            begin
                ex_wb_en = 1'b1;
                ex_lw    = 1'b1;
            end
            msx_pkg::OP_SW:
            begin
                ex_sw = 1'b1;
            end
            msx_pkg::OP_HALT:
            begin
                ex_kind = msx_pkg::FLOW_HALT;
            end
            default:
            begin
                ex_kind = msx_pkg::FLOW_ILLEGAL;
            end
        endcase
    end

    // quotient by reciprocal; exact for every 32-bit sum
    assign ex_sum  = op_a + imm_sext;
    assign ex_prod = 65'(ex_sum) * 65'(RECIP);

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            s2_kind_reg    <= ex_kind;
            s2_boff_reg    <= ex_boff;
            s2_jtgt_reg    <= ex_jtgt;
            s2_wb_en_reg   <= ex_wb_en;
            s2_wb_addr_reg <= ex_wb_addr;
            s2_alu_reg     <= ex_alu;
            s2_lw_reg      <= ex_lw;
            s2_sw_reg      <= ex_sw;
            s2_sum_reg     <= ex_sum;
            s2_q_reg       <= ex_prod[64:KSH];
            s2_store_reg   <= op_b;
        end
    end

    // remainder is below the depth, so only the low address bits matter
    assign s2_qd    = 33'(s2_q_reg) * 33'(MEM_DEPTH);
    assign mem_addr = s2_sum_reg[AW-1:0] - s2_qd[AW-1:0];
    assign dmem_en  = s2_advance && (s2_lw_reg || s2_sw_reg);

    msx_dmem #(
        .DEPTH (MEM_DEPTH)
    ) u_dmem (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_en    (dmem_en),
        .req_we    (s2_sw_reg),
        .req_addr  (mem_addr),
        .req_wdata (s2_store_reg),
        .rdata     (dmem_rdata),
        .init_done (init_done)
    );

    always_ff @(posedge clk)
    begin
        if (s2_advance)
        begin
            s3_kind_reg    <= s2_kind_reg;
            s3_boff_reg    <= s2_boff_reg;
            s3_jtgt_reg    <= s2_jtgt_reg;
            s3_wb_en_reg   <= s2_wb_en_reg;
            s3_wb_addr_reg <= s2_wb_addr_reg;
            s3_alu_reg     <= s2_alu_reg;
            s3_lw_reg      <= s2_lw_reg;
        end
    end

    // commit the register write as the result leaves
    assign s3_wb_data  = s3_lw_reg ? dmem_rdata : s3_alu_reg;
    assign commit.en   = s3_valid_reg && out_ready && s3_wb_en_reg;
    assign commit.addr = s3_wb_addr_reg;
    assign commit.data = s3_wb_data;

    assign out_valid     = s3_valid_reg;
    assign flow_kind     = s3_kind_reg;
    assign branch_offset = s3_boff_reg;
    assign jump_target   = s3_jtgt_reg;

    a_boff_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (flow_kind != 3'(msx_pkg::FLOW_BRANCH)) |-> branch_offset == 16'sd0)
        else $error("branch offset set on a result that is no taken branch");

    a_jtgt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (flow_kind != 3'(msx_pkg::FLOW_JUMP)) |-> jump_target == 26'd0)
        else $error("jump target set on a result that is no jump");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !init_done |-> !in_ready)
        else $error("request accepted during memory clear");

    a_dmem_owner: assert property (@(posedge clk) disable iff (!rst_n)
        dmem_en |-> s2_valid_reg && init_done)
        else $error("data memory access without a live S2 instruction");

    a_hazard_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && load_hazard |=> s1_valid_reg && $stable(s1_instr_reg))
        else $error("instruction left S1 while waiting on a load");

    a_commit_seq: assert property (@(posedge clk) disable iff (!rst_n)
        commit.en |-> s3_kind_reg == msx_pkg::FLOW_SEQ)
        else $error("register write from a non-sequential instruction");

endmodule
